/* design/sync_word_frame_deframer_router_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sync word deframer and router
// Each macro checks on the rising edge of clk and is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_DEFRAMER_ROUTER_ASSERT_SVH
`define SYNC_WORD_FRAME_DEFRAMER_ROUTER_ASSERT_SVH
`ifndef SYNTHESIS
// Property must hold on every edge outside reset
`define SWFDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset
`define SWFDR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SWFDR_ASSERT(lbl, prop, msg)
`define SWFDR_NEVER(lbl, expr, msg)
`endif
`endif

/* design/swfdr_pkg.sv */
// ----------------------------------------------------------------------------
// swfdr_pkg
// Shared constants, codes and types of the sync word deframer and router.
// ----------------------------------------------------------------------------
package swfdr_pkg;

  // Route table geometry
  localparam int ROUTE_DEPTH = 256;
  localparam int ROUTE_AW    = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int DEST_W      = 16;

  // Sync word 3C 5A 7E 69, split into the held history and the closing byte
  localparam logic [23:0] SYNC_HEAD = 24'h3C5A7E;
  localparam logic [7:0]  SYNC_TAIL = 8'h69;

  // Header layout: subject, path, length, four bytes each
  localparam logic [3:0] SUBJ_END = 4'd4;
  localparam logic [3:0] PATH_END = 4'd8;
  localparam logic [3:0] HDR_LAST = 4'd11;

  // Configuration
  localparam logic [31:0] MAX_LEN_RESET = 32'h1000_0000;

  typedef enum logic [1:0] {
    CFG_MAX_LEN     = 2'd0,
    CFG_BYTE_ORDER  = 2'd1,
    CFG_ROUTE_COUNT = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [31:0] max_len;
    logic        big;
    logic [8:0]  route_count;
  } cfg_t;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // What an accepted stream byte asks of the routing stage
  typedef enum logic [1:0] {
    K_DROP  = 2'd0,  // oversize header: drop marker
    K_EMPTY = 2'd1,  // header complete, zero length
    K_OPEN  = 2'd2,  // header complete, payload follows
    K_BYTE  = 2'd3   // one payload byte
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        subject_ok;
    logic [31:0] path;
    logic [7:0]  data;
    logic        last;
  } req_t;

  typedef struct packed {
    logic                en;
    logic [ROUTE_AW-1:0] addr;
    logic [DEST_W-1:0]   data;
  } tbl_wr_t;

endpackage

/* design/swfdr_ram.sv */
// ----------------------------------------------------------------------------
// swfdr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module swfdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/swfdr_parser.sv */
// ----------------------------------------------------------------------------
// swfdr_parser
// Sync hunt, header collection and payload count for the received stream.
// Issues one request per significant word and the route table read address.
// ----------------------------------------------------------------------------
module swfdr_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          command,
  input  logic [7:0]                    rx_byte,
  input  swfdr_pkg::cfg_t               cfg,
  output swfdr_pkg::req_t               req,
  output logic [swfdr_pkg::ROUTE_AW-1:0] rd_addr
);

  swfdr_pkg::phase_t phase, phase_next;
  logic [23:0] sync_history, sync_history_next;
  logic [3:0]  hdr_count, hdr_count_next;
  logic [31:0] subject_word, subject_word_next;
  logic [31:0] path_word, path_word_next;
  logic [31:0] remaining, remaining_next;
  logic [31:0] length_word;

  // Shift one header byte into a word in the configured order
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [7:0] b,
                                           input logic big);
    logic [31:0] r;
    if (big) begin
      r = {w[23:0], b};
    end else begin
      r = {b, w[31:8]};
    end
    return r;
  endfunction

  // Length word as it stands after this byte
  assign length_word = put_byte(remaining, rx_byte, cfg.big);

  // Table lookups always use the subject of the current frame
  assign rd_addr = swfdr_pkg::ROUTE_AW'(subject_word);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= swfdr_pkg::PH_HUNT;
      sync_history <= '0;
      hdr_count    <= '0;
      subject_word <= '0;
      path_word    <= '0;
      remaining    <= '0;
    end else begin
      phase        <= phase_next;
      sync_history <= sync_history_next;
      hdr_count    <= hdr_count_next;
      subject_word <= subject_word_next;
      path_word    <= path_word_next;
      remaining    <= remaining_next;
    end
  end

  // Next state and request
  always_comb begin
    phase_next        = phase;
    sync_history_next = sync_history;
    hdr_count_next    = hdr_count;
    subject_word_next = subject_word;
    path_word_next    = path_word;
    remaining_next    = remaining;
    req               = '0;
    req.path          = path_word;
    req.data          = rx_byte;
    if (accept && !command) begin
      unique case (phase)
        swfdr_pkg::PH_HEADER: begin
          hdr_count_next = hdr_count + 4'd1;
          if (hdr_count < swfdr_pkg::SUBJ_END) begin
            subject_word_next = put_byte(subject_word, rx_byte, cfg.big);
          end else if (hdr_count < swfdr_pkg::PATH_END) begin
            path_word_next = put_byte(path_word, rx_byte, cfg.big);
          end else begin
            remaining_next = length_word;
          end
          // Header complete: drop, empty frame or open payload
          if (hdr_count == swfdr_pkg::HDR_LAST) begin
            hdr_count_next = '0;
            req.valid      = 1'b1;
            if (length_word > cfg.max_len) begin
              phase_next     = swfdr_pkg::PH_HUNT;
              remaining_next = '0;
              req.kind       = swfdr_pkg::K_DROP;
              req.last       = 1'b1;
            end else begin
              req.subject_ok = (subject_word < {23'd0, cfg.route_count}) &&
                               (subject_word < 32'(swfdr_pkg::ROUTE_DEPTH));
              if (length_word == '0) begin
                phase_next = swfdr_pkg::PH_HUNT;
                req.kind   = swfdr_pkg::K_EMPTY;
                req.last   = 1'b1;
              end else begin
                phase_next = swfdr_pkg::PH_PAYLOAD;
                req.kind   = swfdr_pkg::K_OPEN;
              end
            end
          end
        end
        swfdr_pkg::PH_PAYLOAD: begin
          // Count off one payload byte
          remaining_next = remaining - 32'd1;
          req.valid      = 1'b1;
          req.kind       = swfdr_pkg::K_BYTE;
          req.last       = (remaining == 32'd1);
          if (remaining == 32'd1) begin
            phase_next = swfdr_pkg::PH_HUNT;
          end
        end
        default: begin
          // Hunt: sliding match on the sync word
          phase_next = swfdr_pkg::PH_HUNT;
          if (sync_history == swfdr_pkg::SYNC_HEAD && rx_byte == swfdr_pkg::SYNC_TAIL) begin
            sync_history_next = '0;
            hdr_count_next    = '0;
            phase_next        = swfdr_pkg::PH_HEADER;
          end else begin
            sync_history_next = {sync_history[15:0], rx_byte};
          end
        end
      endcase
    end
  end

endmodule

/* design/swfdr_router.sv */
// ----------------------------------------------------------------------------
// swfdr_router
// Route table memory, lookup stage and output register. Decides routing at
// header completion and attaches the destination to each emitted result.
// ----------------------------------------------------------------------------
module swfdr_router (
  input  logic                           clk,
  input  logic                           rst,
  input  swfdr_pkg::req_t                req,
  input  logic [swfdr_pkg::ROUTE_AW-1:0] rd_addr,
  input  swfdr_pkg::tbl_wr_t             tbl_wr,
  input  logic                           out_stall,
  output logic                           hold,
  output logic                           out_valid,
  output logic [15:0]                    dest_instance,
  output logic [31:0]                    path_number,
  output logic [7:0]                     payload_byte,
  output logic                           has_byte,
  output logic                           last_of_frame,
  output logic                           oversize_drop
);

  logic [swfdr_pkg::ROUTE_DEPTH-1:0] entry_valid;
  logic                              rd_valid;
  logic [swfdr_pkg::DEST_W-1:0]      rd_data;
  logic [swfdr_pkg::DEST_W-1:0]      dest;
  logic                              s1_valid;
  swfdr_pkg::req_t                   s1;
  logic                              s1_move;
  logic                              frame_routed;
  logic                              routed;
  logic                              emit;

  // Route table
  swfdr_ram #(
    .WIDTH (swfdr_pkg::DEST_W),
    .DEPTH (swfdr_pkg::ROUTE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_wr.en),
    .waddr (tbl_wr.addr),
    .wdata (tbl_wr.data),
    .re    (req.valid),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Written marks: an entry never written reads as not routed
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (tbl_wr.en) begin
      entry_valid[tbl_wr.addr] <= 1'b1;
    end
  end

  // Mark read alongside the table data
  always_ff @(posedge clk) begin
    if (req.valid) begin
      rd_valid <= entry_valid[rd_addr];
    end
  end

  // Lookup stage advances when the output register is free or being taken
  assign s1_move = !out_valid || !out_stall;
  assign hold    = s1_valid && !s1_move;

  assign dest   = rd_valid ? rd_data : '0;
  assign routed = s1.subject_ok && (dest != '0);

  always_comb begin
    emit = 1'b0;
    if (s1_valid) begin
      unique case (s1.kind)
        swfdr_pkg::K_DROP:  emit = 1'b1;
        swfdr_pkg::K_EMPTY: emit = routed;
        swfdr_pkg::K_OPEN:  emit = 1'b0;
        swfdr_pkg::K_BYTE:  emit = frame_routed;
        default:            emit = 1'b0;
      endcase
    end
  end

  // Lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      frame_routed <= 1'b0;
    end else begin
      if (req.valid) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      // Latch the routing decision as the header completes
      if (s1_valid && s1_move &&
          (s1.kind == swfdr_pkg::K_EMPTY || s1.kind == swfdr_pkg::K_OPEN)) begin
        frame_routed <= routed;
      end
    end
  end

  // Lookup stage payload
  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1 <= req;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= emit;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_move && emit) begin
      last_of_frame <= s1.last;
      if (s1.kind == swfdr_pkg::K_DROP) begin
        dest_instance <= '0;
        path_number   <= '0;
        payload_byte  <= '0;
        has_byte      <= 1'b0;
        oversize_drop <= 1'b1;
      end else begin
        dest_instance <= dest;
        path_number   <= s1.path;
        payload_byte  <= (s1.kind == swfdr_pkg::K_BYTE) ? s1.data : 8'd0;
        has_byte      <= (s1.kind == swfdr_pkg::K_BYTE);
        oversize_drop <= 1'b0;
      end
    end
  end

  `include "sync_word_frame_deframer_router_assert.svh"

  `SWFDR_NEVER(a_rd_wr_clash, req.valid && tbl_wr.en, "table read and write in one cycle")
  `SWFDR_NEVER(a_req_on_hold, hold && req.valid, "request entered a held lookup stage")
  `SWFDR_ASSERT(a_hold_keeps, hold |=> s1_valid, "held lookup stage lost its word")
  `SWFDR_ASSERT(a_drop_bare,
    out_valid && oversize_drop |-> last_of_frame && !has_byte && dest_instance == '0,
    "drop marker carries frame data")

endmodule

/* design/sync_word_frame_deframer_router.sv */
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_router
// Byte stream deframer: sync word hunt, 12-byte header, payload routing
// through a route table written by command words.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid, in_stall | command, rx_byte, route_index,
//           |           |                    | route_dest
//   out     | out       | out_valid,out_stall| dest_instance, path_number, ...
//
// One word is accepted per cycle while the input is not stalled; a result is
// registered by the route table read and then by the output register.
// Reset clears the parser, the configuration and the table written marks;
// no clearing pass is needed.
// A stall on the output holds the lookup stage, which then stalls the input.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_router (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  route_index,
  input  logic [15:0] route_dest,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] dest_instance,
  output logic [31:0] path_number,
  output logic [7:0]  payload_byte,
  output logic        has_byte,
  output logic        last_of_frame,
  output logic        oversize_drop
);

  swfdr_pkg::cfg_t                cfg;
  swfdr_pkg::req_t                req;
  swfdr_pkg::tbl_wr_t             tbl_wr;
  logic [swfdr_pkg::ROUTE_AW-1:0] rd_addr;
  logic                           accept;
  logic                           hold;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_len     <= swfdr_pkg::MAX_LEN_RESET;
      cfg.big         <= 1'b0;
      cfg.route_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swfdr_pkg::CFG_MAX_LEN:     cfg.max_len     <= cfg_data;
        swfdr_pkg::CFG_BYTE_ORDER:  cfg.big         <= cfg_data[0];
        swfdr_pkg::CFG_ROUTE_COUNT: cfg.route_count <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // Route table writes from command words; drop indexes beyond the table
  always_comb begin
    tbl_wr.en   = accept && command &&
                  ({24'd0, route_index} < 32'(swfdr_pkg::ROUTE_DEPTH));
    tbl_wr.addr = swfdr_pkg::ROUTE_AW'(route_index);
    tbl_wr.data = route_dest;
  end

  swfdr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .command (command),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .req     (req),
    .rd_addr (rd_addr)
  );

  swfdr_router u_router (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rd_addr       (rd_addr),
    .tbl_wr        (tbl_wr),
    .out_stall     (out_stall),
    .hold          (hold),
    .out_valid     (out_valid),
    .dest_instance (dest_instance),
    .path_number   (path_number),
    .payload_byte  (payload_byte),
    .has_byte      (has_byte),
    .last_of_frame (last_of_frame),
    .oversize_drop (oversize_drop)
  );

endmodule
